>>> sv/assert_macros.svh
// assertion macros used by the rtl file that carries checks
// no dependencies; plain concurrent assertions with a clock and an active-low reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_AT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  `ASSERT_AT(label, clk, rst_n, !(expr), msg)

`endif

>>> sv/asrm_pkg.sv
// shared types, constants and the init frame table of the three-wire spi master
// no dependencies
package asrm_pkg;

  localparam int unsigned NUM_CHIPS_DEF   = 4;
  localparam int unsigned MAX_CHIPS       = 8;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;
  localparam int unsigned CS_W            = 4;
  localparam int unsigned FRAME_BITS      = 24;
  localparam int unsigned CMD_BITS        = 16;
  localparam int unsigned CNT_W           = 5;

  // instruction byte of a read frame (read flag set)
  localparam logic [7:0] READ_CMD_HI = 8'h80;

  // converter registers touched by the init sequences
  localparam logic [7:0] REG_POWER_MODES = 8'h08;
  localparam logic [7:0] REG_OUTPUT_MODE = 8'h14;
  localparam logic [7:0] REG_TRANSFER    = 8'hff;
  localparam logic [7:0] PWR_NORMAL      = 8'h00;
  localparam logic [7:0] PWR_DOWN        = 8'h01;
  localparam logic [7:0] OUT_MODE_VAL    = 8'h40;
  localparam logic [7:0] TRANSFER_GO     = 8'h01;

  // start request carried by an input beat
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_INIT  = 2'd3
  } cmd_e;

  // frame engine state
  typedef enum logic [1:0] {
    FR_IDLE  = 2'd0,
    FR_WRITE = 2'd1,
    FR_READ  = 2'd2,
    FR_GAP   = 2'd3
  } frame_e;

  // decoded beat as queued between front and back
  typedef struct packed {
    cmd_e                 kind;
    logic [7:0]           addr;
    logic [7:0]           data;
    logic [MAX_CHIPS-1:0] rd_sel;
    logic                 pnorm;
    logic                 din;
  } cmd_t;

  // one result beat
  typedef struct packed {
    logic [CS_W-1:0] cs_n;
    logic            sclk;
    logic            sdio_out;
    logic            sdio_drive;
    logic [7:0]      read_data;
    logic            read_done;
    logic            busy;
    logic            rejected;
  } res_t;

  // address and data of init frame idx; past the end, normal mode repeats the last entry and power down gives zero
  function automatic logic [15:0] init_frame(input logic normal, input logic [1:0] idx);
    logic [15:0] frame;
    if (normal) begin
      unique case (idx)
        2'd0:    frame = {REG_POWER_MODES, PWR_NORMAL};
        2'd1:    frame = {REG_OUTPUT_MODE, OUT_MODE_VAL};
        default: frame = {REG_TRANSFER, TRANSFER_GO};
      endcase
    end else begin
      unique case (idx)
        2'd0:    frame = {REG_POWER_MODES, PWR_DOWN};
        2'd1:    frame = {REG_TRANSFER, TRANSFER_GO};
        default: frame = 16'h0000;
      endcase
    end
    return frame;
  endfunction

endpackage

>>> sv/adc_spi_register_master.sv
// top level of the three-wire spi master for the converter chips
// depends on asrm_pkg, asrm_front, asrm_fifo, asrm_back, assert_macros.svh
//
//   channel  | handshake             | beat
//   ---------+-----------------------+----------------------------------------------
//   input    | in_valid_i/in_stall_o | mode, reg_address, value, power_normal, sdio_in
//   output   | out_valid_o/out_stall_i | cs_n, sclk, sdio_out, sdio_drive, read_data,
//            |                       | read_done, busy_res, rejected
//
// one beat per cycle in and out while neither side stalls; each beat is one half phase of the serial clock
// a beat passes through the queue before its result is registered in the output register
// a queue of QUEUE_DEPTH beats lets the input side run while the output stalls
// reset is asynchronous and clears every control register at once, no clearing pass;
// queue entries and the result register carry data only and are not reset
`include "assert_macros.svh"

module adc_spi_register_master #(
  parameter int unsigned NUM_CHIPS   = asrm_pkg::NUM_CHIPS_DEF,
  parameter int unsigned QUEUE_DEPTH = asrm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] mode_i,
  input  logic [7:0] reg_address_i,
  input  logic [7:0] value_i,
  input  logic       power_normal_i,
  input  logic       sdio_in_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [3:0] cs_n_o,
  output logic       sclk_o,
  output logic       sdio_out_o,
  output logic       sdio_drive_o,
  output logic [7:0] read_data_o,
  output logic       read_done_o,
  output logic       busy_res_o,
  output logic       rejected_o
);
  import asrm_pkg::*;

  logic q_full;
  logic push;
  logic pop;
  logic q_valid;
  cmd_t cmd_in;
  cmd_t cmd_q;
  res_t res;

  // decode of input beats
  asrm_front #(
    .NUM_CHIPS(NUM_CHIPS)
  ) u_front (
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .mode_i        (mode_i),
    .reg_address_i (reg_address_i),
    .value_i       (value_i),
    .power_normal_i(power_normal_i),
    .sdio_in_i     (sdio_in_i),
    .q_full_i      (q_full),
    .push_o        (push),
    .cmd_o         (cmd_in)
  );

  // queue between front and back
  asrm_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (cmd_in),
    .pop_i  (pop),
    .full_o (q_full),
    .valid_o(q_valid),
    .data_o (cmd_q)
  );

  // frame engine and output register
  asrm_back #(
    .NUM_CHIPS(NUM_CHIPS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .cmd_i      (cmd_q),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .res_o      (res)
  );

  // result beat onto the pins
  assign cs_n_o       = res.cs_n;
  assign sclk_o       = res.sclk;
  assign sdio_out_o   = res.sdio_out;
  assign sdio_drive_o = res.sdio_drive;
  assign read_data_o  = res.read_data;
  assign read_done_o  = res.read_done;
  assign busy_res_o   = res.busy;
  assign rejected_o   = res.rejected;

  // checks
  `ASSERT_AT(a_done_released, clk_i, rst_ni, out_valid_o && read_done_o |-> busy_res_o && !sdio_drive_o, "read done outside a released read phase")
  `ASSERT_AT(a_reject_busy, clk_i, rst_ni, out_valid_o && rejected_o |-> busy_res_o, "start rejected while idle")
  `ASSERT_AT(a_queue_drains, clk_i, rst_ni, q_valid && !out_stall_i |=> out_valid_o, "queued beat not played")
  `ASSERT_NEVER(a_sclk_idle, clk_i, rst_ni, out_valid_o && sclk_o && !busy_res_o, "serial clock high while idle")

endmodule

>>> sv/asrm_front.sv
// front end: takes input beats, decodes the start request and chip number
// depends on asrm_pkg
module asrm_front #(
  parameter int unsigned NUM_CHIPS = asrm_pkg::NUM_CHIPS_DEF
) (
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        mode_i,
  input  logic [7:0]        reg_address_i,
  input  logic [7:0]        value_i,
  input  logic              power_normal_i,
  input  logic              sdio_in_i,
  input  logic              q_full_i,
  output logic              push_o,
  output asrm_pkg::cmd_t    cmd_o
);
  import asrm_pkg::*;

  logic [MAX_CHIPS-1:0] rd_sel;

  // chip number 1..NUM_CHIPS to one-hot select, anything else selects none
  always_comb begin
    for (int k = 0; k < MAX_CHIPS; k++) begin
      rd_sel[k] = (k < NUM_CHIPS) && (value_i == 8'(k + 1));
    end
  end

  // beat enters the queue whenever there is room
  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    cmd_o.kind   = cmd_e'(mode_i);
    cmd_o.addr   = reg_address_i;
    cmd_o.data   = value_i;
    cmd_o.rd_sel = rd_sel;
    cmd_o.pnorm  = power_normal_i;
    cmd_o.din    = sdio_in_i;
  end

endmodule

>>> sv/asrm_fifo.sv
// short queue of decoded beats between front and back
// depends on asrm_pkg
module asrm_fifo #(
  parameter int unsigned DEPTH = asrm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  asrm_pkg::cmd_t data_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           valid_o,
  output asrm_pkg::cmd_t data_o
);
  import asrm_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  cmd_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  // pointer wrap and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    count_d = count_q + CntW'(push_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> sv/asrm_back.sv
// back end: frame engine that plays one phase per queued beat, plus the output register
// depends on asrm_pkg
module asrm_back #(
  parameter int unsigned NUM_CHIPS = asrm_pkg::NUM_CHIPS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  asrm_pkg::cmd_t cmd_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output asrm_pkg::res_t res_o
);
  import asrm_pkg::*;

  localparam int unsigned SelExtW = (NUM_CHIPS > CS_W) ? NUM_CHIPS : CS_W;

  frame_e               kind_q, kind_d;
  logic [23:0]          shift_q, shift_d;
  logic [7:0]           shift_in_q, shift_in_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 phase_q, phase_d;
  logic [NUM_CHIPS-1:0] sel_q, sel_d;
  logic [1:0]           step_q, step_d;
  logic                 normal_q, normal_d;
  logic                 out_valid_q;
  res_t                 res_q, res_d;
  logic                 fire;
  logic                 inbit;
  logic [1:0]           idx;
  logic [SelExtW-1:0]   sel_ext;

  // one beat is played when the output register can take its result
  assign fire        = q_valid_i && (!out_valid_q || !out_stall_i);
  assign pop_o       = fire;
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q     <= FR_IDLE;
      shift_q    <= '0;
      shift_in_q <= '0;
      cnt_q      <= '0;
      phase_q    <= 1'b0;
      sel_q      <= '0;
      step_q     <= '0;
      normal_q   <= 1'b0;
    end else if (fire) begin
      kind_q     <= kind_d;
      shift_q    <= shift_d;
      shift_in_q <= shift_in_d;
      cnt_q      <= cnt_d;
      phase_q    <= phase_d;
      sel_q      <= sel_d;
      step_q     <= step_d;
      normal_q   <= normal_d;
    end
  end

  // next state and result of one phase
  always_comb begin
    kind_d     = kind_q;
    shift_d    = shift_q;
    shift_in_d = shift_in_q;
    cnt_d      = cnt_q;
    phase_d    = phase_q;
    sel_d      = sel_q;
    step_d     = step_q;
    normal_d   = normal_q;
    inbit      = 1'b0;
    idx        = '0;
    sel_ext    = '0;
    res_d      = '{cs_n: '1, sclk: 1'b0, sdio_out: 1'b0, sdio_drive: 1'b1,
                   read_data: '0, read_done: 1'b0, busy: 1'b0, rejected: 1'b0};

    // start request, honored only from idle
    if (cmd_i.kind != CMD_TICK) begin
      if (kind_q != FR_IDLE) begin
        res_d.rejected = 1'b1;
      end else begin
        unique case (cmd_i.kind)
          CMD_WRITE: begin
            step_d  = '0;
            shift_d = {8'h00, cmd_i.addr, cmd_i.data};
            sel_d   = '1;
            kind_d  = FR_WRITE;
            cnt_d   = '0;
            phase_d = 1'b0;
          end
          CMD_READ: begin
            step_d  = '0;
            shift_d = {READ_CMD_HI, cmd_i.addr, 8'h00};
            sel_d   = cmd_i.rd_sel[NUM_CHIPS-1:0];
            kind_d  = FR_READ;
            cnt_d   = '0;
            phase_d = 1'b0;
          end
          CMD_INIT: begin
            normal_d = cmd_i.pnorm;
            step_d   = cmd_i.pnorm ? 2'd2 : 2'd1;
            shift_d  = {8'h00, init_frame(cmd_i.pnorm, 2'd0)};
            sel_d    = '1;
            kind_d   = FR_WRITE;
            cnt_d    = '0;
            phase_d  = 1'b0;
          end
          CMD_TICK: begin
          end
        endcase
      end
    end

    // phase of the current frame
    unique case (kind_d)
      FR_IDLE: begin
      end
      FR_GAP: begin
        // chip select stays high this phase while the next init frame loads
        res_d.busy = 1'b1;
        idx        = (normal_d ? 2'd3 : 2'd2) - step_d;
        shift_d    = {8'h00, init_frame(normal_d, idx)};
        sel_d      = '1;
        kind_d     = FR_WRITE;
        cnt_d      = '0;
        phase_d    = 1'b0;
        step_d     = step_d - 2'd1;
      end
      FR_WRITE, FR_READ: begin
        inbit            = (kind_d == FR_READ) && (cnt_d >= CNT_W'(CMD_BITS));
        sel_ext          = SelExtW'(sel_d);
        res_d.busy       = 1'b1;
        res_d.cs_n       = ~sel_ext[CS_W-1:0];
        res_d.sclk       = phase_d;
        res_d.sdio_drive = !inbit;
        res_d.sdio_out   = inbit ? 1'b0 : shift_d[23];
        if (!phase_d) begin
          phase_d = 1'b1;
        end else begin
          // rising edge: sample on read bits, advance the bit
          if (inbit) begin
            shift_in_d = {shift_in_d[6:0], cmd_i.din};
          end
          shift_d = {shift_d[22:0], 1'b0};
          cnt_d   = cnt_d + 1'b1;
          phase_d = 1'b0;
          if (cnt_d >= CNT_W'(FRAME_BITS)) begin
            cnt_d = '0;
            if (kind_d == FR_READ) begin
              res_d.read_done = 1'b1;
              res_d.read_data = shift_in_d;
              kind_d          = FR_IDLE;
              sel_d           = '0;
            end else if (step_d != '0) begin
              kind_d = FR_GAP;
            end else begin
              kind_d = FR_IDLE;
              sel_d  = '0;
            end
          end
        end
      end
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

endmodule

>>> dv/tb_top.sv
// self-checking testbench for the three-wire spi master adc_spi_register_master
// depends on asrm_pkg and the rtl; drives phase beats from a queue, predicts every
// result beat with its own copy of the frame engine and compares pin levels field by field
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import asrm_pkg::*;

  localparam int unsigned FRAME_PHASES = 2 * FRAME_BITS;
  localparam int unsigned IDLE_PCT     = 37;
  localparam int unsigned RANDOM_BEATS = 80;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned DRAIN_CYCLES = 8;

  // one input beat as queued for the driver
  typedef struct {
    cmd_e       cmd;
    logic [7:0] addr;
    logic [7:0] val;
    logic       pnorm;
    logic       din;
  } beat_t;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // dut ports
  logic       in_valid_i     = 1'b0;
  logic       in_stall_o;
  logic [1:0] mode_i         = CMD_TICK;
  logic [7:0] reg_address_i  = 8'h00;
  logic [7:0] value_i        = 8'h00;
  logic       power_normal_i = 1'b0;
  logic       sdio_in_i      = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i    = 1'b0;
  logic [3:0] cs_n_o;
  logic       sclk_o;
  logic       sdio_out_o;
  logic       sdio_drive_o;
  logic [7:0] read_data_o;
  logic       read_done_o;
  logic       busy_res_o;
  logic       rejected_o;

  adc_spi_register_master u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .reg_address_i  (reg_address_i),
    .value_i        (value_i),
    .power_normal_i (power_normal_i),
    .sdio_in_i      (sdio_in_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .cs_n_o         (cs_n_o),
    .sclk_o         (sclk_o),
    .sdio_out_o     (sdio_out_o),
    .sdio_drive_o   (sdio_drive_o),
    .read_data_o    (read_data_o),
    .read_done_o    (read_done_o),
    .busy_res_o     (busy_res_o),
    .rejected_o     (rejected_o)
  );

  // bookkeeping
  beat_t pending_q[$];
  res_t  exp_pins_q[$];
  beat_t next_beat;
  res_t  want_pins;
  int    frame_left   = 0;
  int    beats_made   = 0;
  int    beats_in     = 0;
  int    results_seen = 0;
  int    err_count    = 0;
  int    quiet_cycles = 0;
  logic  no_idle;

  // burst with no idling on either side
  assign no_idle = (beats_in >= 250) && (beats_in < 450);

  // predictor state: frame engine of the master
  logic [23:0] mdl_shift_out   = '0;
  logic [7:0]  mdl_shift_in    = '0;
  logic [4:0]  mdl_bits        = '0;
  logic        mdl_phase       = 1'b0;
  frame_e      mdl_kind        = FR_IDLE;
  logic [3:0]  mdl_sel         = '0;
  logic [1:0]  mdl_frames_left = '0;
  logic        mdl_normal      = 1'b0;

  // address and data of the queued init frames, power down row then normal row
  logic [15:0] init_words [2][3];
  initial begin
    init_words[0][0] = {REG_POWER_MODES, PWR_DOWN};
    init_words[0][1] = {REG_TRANSFER, TRANSFER_GO};
    init_words[0][2] = 16'h0000;
    init_words[1][0] = {REG_POWER_MODES, PWR_NORMAL};
    init_words[1][1] = {REG_OUTPUT_MODE, OUT_MODE_VAL};
    init_words[1][2] = {REG_TRANSFER, TRANSFER_GO};
  end

  task automatic load_write_frame(input logic [15:0] word);
    mdl_shift_out = {8'h00, word};
    mdl_sel       = '1;
    mdl_kind      = FR_WRITE;
    mdl_bits      = '0;
    mdl_phase     = 1'b0;
  endtask

  // one accepted beat: update the engine and queue the pin levels it must show
  task automatic advance_spi_phase(input beat_t b);
    res_t r;
    logic rx_bit;
    int   total;
    r            = '0;
    r.cs_n       = '1;
    r.sdio_drive = 1'b1;

    // start requests only take effect when idle
    if (b.cmd != CMD_TICK) begin
      if (mdl_kind != FR_IDLE) begin
        r.rejected = 1'b1;
      end else begin
        case (b.cmd)
          CMD_WRITE: begin
            mdl_frames_left = '0;
            load_write_frame({b.addr, b.val});
          end
          CMD_READ: begin
            mdl_frames_left = '0;
            mdl_shift_out   = {READ_CMD_HI, b.addr, 8'h00};
            mdl_sel         = (b.val >= 1 && b.val <= NUM_CHIPS_DEF) ?
                              4'(1 << (b.val - 1)) : 4'h0;
            mdl_kind        = FR_READ;
            mdl_bits        = '0;
            mdl_phase       = 1'b0;
          end
          default: begin
            mdl_normal      = b.pnorm;
            mdl_frames_left = b.pnorm ? 2'd2 : 2'd1;
            load_write_frame(init_words[b.pnorm][0]);
          end
        endcase
      end
    end

    // gap between queued init frames loads the next one
    if (mdl_kind == FR_GAP) begin
      total  = mdl_normal ? 3 : 2;
      r.busy = 1'b1;
      load_write_frame(init_words[mdl_normal][total - mdl_frames_left]);
      mdl_frames_left = mdl_frames_left - 2'd1;
    end else if (mdl_kind == FR_WRITE || mdl_kind == FR_READ) begin
      rx_bit = (mdl_kind == FR_READ) && (mdl_bits >= CMD_BITS);
      r.busy = 1'b1;
      r.cs_n = ~mdl_sel;
      r.sclk = mdl_phase;
      if (rx_bit) begin
        r.sdio_drive = 1'b0;
      end else begin
        r.sdio_out = mdl_shift_out[23];
      end
      // low phase then high phase; bit advances on the high phase
      if (!mdl_phase) begin
        mdl_phase = 1'b1;
      end else begin
        if (rx_bit) mdl_shift_in = {mdl_shift_in[6:0], b.din};
        mdl_shift_out = {mdl_shift_out[22:0], 1'b0};
        mdl_bits      = mdl_bits + 5'd1;
        mdl_phase     = 1'b0;
        if (mdl_bits >= FRAME_BITS) begin
          mdl_bits = '0;
          if (mdl_kind == FR_READ) begin
            r.read_done = 1'b1;
            r.read_data = mdl_shift_in;
            mdl_kind    = FR_IDLE;
            mdl_sel     = '0;
          end else if (mdl_frames_left != 0) begin
            mdl_kind = FR_GAP;
          end else begin
            mdl_kind = FR_IDLE;
            mdl_sel  = '0;
          end
        end
      end
    end
    exp_pins_q.push_back(r);
  endtask

  // mismatch reporting
  task automatic note_mismatch(input string msg);
    $display("mismatch: %s", msg);
    err_count++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want)
      note_mismatch($sformatf("%s got %0h expected %0h at result %0d",
                              name, got, want, results_seen));
  endtask

  // stimulus queue; tracks how many phases the current frame still needs
  task automatic push_beat(input cmd_e cmd, input logic [7:0] addr, input logic [7:0] val,
                           input logic pnorm, input logic din);
    beat_t b;
    b.cmd   = cmd;
    b.addr  = addr;
    b.val   = val;
    b.pnorm = pnorm;
    b.din   = din;
    pending_q.push_back(b);
    beats_made++;
    if (cmd != CMD_TICK && frame_left == 0) begin
      if (cmd == CMD_INIT)
        frame_left = pnorm ? 3 * FRAME_PHASES + 2 : 2 * FRAME_PHASES + 1;
      else
        frame_left = FRAME_PHASES;
    end
    if (frame_left > 0) frame_left--;
  endtask

  // ticks until stop_at phases remain; stray starts land while busy
  // din_sel: 0 or 1 fixed line level, 2 random
  task automatic fill_ticks(input int stop_at, input int stray_pct, input int din_sel);
    logic din;
    while (frame_left > stop_at) begin
      din = (din_sel == 2) ? 1'($urandom_range(1)) : 1'(din_sel);
      if ($urandom_range(99) < stray_pct)
        push_beat(cmd_e'($urandom_range(3, 1)), 8'($urandom_range(255)),
                  8'($urandom_range(255)), 1'($urandom_range(1)), din);
      else
        push_beat(CMD_TICK, 8'($urandom_range(255)), 8'($urandom_range(255)),
                  1'($urandom_range(1)), din);
    end
  endtask

  task automatic idle_tick();
    push_beat(CMD_TICK, 8'($urandom_range(255)), 8'($urandom_range(255)),
              1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  // input driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (pending_q.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
        next_beat = pending_q.pop_front();
        in_valid_i     <= 1'b1;
        mode_i         <= next_beat.cmd;
        reg_address_i  <= next_beat.addr;
        value_i        <= next_beat.val;
        power_normal_i <= next_beat.pnorm;
        sdio_in_i      <= next_beat.din;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // output stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= !no_idle && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // input monitor feeds the predictor
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      advance_spi_phase('{cmd_e'(mode_i), reg_address_i, value_i, power_normal_i, sdio_in_i});
      beats_in++;
    end
  end

  // output monitor compares against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (exp_pins_q.size() == 0) begin
        note_mismatch($sformatf("result %0d with nothing expected", results_seen));
      end else begin
        want_pins = exp_pins_q.pop_front();
        check_field("cs_n", cs_n_o, want_pins.cs_n);
        check_field("sclk", sclk_o, want_pins.sclk);
        check_field("sdio_out", sdio_out_o, want_pins.sdio_out);
        check_field("sdio_drive", sdio_drive_o, want_pins.sdio_drive);
        check_field("read_data", read_data_o, want_pins.read_data);
        check_field("read_done", read_done_o, want_pins.read_done);
        check_field("busy_res", busy_res_o, want_pins.busy);
        check_field("rejected", rejected_o, want_pins.rejected);
      end
      results_seen++;
    end
  end

  // watchdog on cycles with no beat moving
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no beat moved for %0d cycles", quiet_cycles);
        $display("tb_top failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // sequence of the run
  initial begin
    int pick;
    int chip;
    int rnd_target;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: idle tick, write extremes, reject on the final phase
    idle_tick();
    push_beat(CMD_WRITE, 8'h00, 8'h00, 1'b0, 1'b0);
    fill_ticks(0, 0, 0);
    push_beat(CMD_WRITE, 8'hff, 8'hff, 1'b1, 1'b1);
    fill_ticks(1, 0, 1);
    push_beat(CMD_READ, 8'h5a, 8'h01, 1'b0, 1'b1);

    // reads of every chip, with starts rejected in the middle of one
    for (chip = 1; chip <= 4; chip++) begin
      push_beat(CMD_READ, 8'($urandom_range(255)), 8'(chip), 1'b0, 1'b0);
      if (chip == 3) begin
        fill_ticks(20, 0, 2);
        push_beat(CMD_WRITE, 8'h11, 8'h22, 1'b0, 1'b1);
        push_beat(CMD_INIT, 8'h33, 8'h44, 1'b1, 1'b0);
      end
      fill_ticks(0, 0, (chip == 1) ? 1 : (chip == 2) ? 0 : 2);
    end

    // reads with no chip selected
    push_beat(CMD_READ, 8'h00, 8'h00, 1'b0, 1'b1);
    fill_ticks(0, 0, 2);
    push_beat(CMD_READ, 8'hff, 8'h05, 1'b1, 1'b0);
    fill_ticks(0, 0, 2);
    push_beat(CMD_READ, 8'h80, 8'hff, 1'b0, 1'b1);
    fill_ticks(0, 0, 2);

    // power down init, start rejected in the gap
    push_beat(CMD_INIT, 8'h00, 8'h00, 1'b0, 1'b0);
    fill_ticks(FRAME_PHASES + 1, 0, 2);
    push_beat(CMD_WRITE, 8'h01, 8'h02, 1'b0, 1'b0);
    fill_ticks(0, 0, 2);

    // normal init, starts rejected in both gaps
    push_beat(CMD_INIT, 8'hff, 8'hff, 1'b1, 1'b1);
    fill_ticks(2 * FRAME_PHASES + 2, 0, 2);
    push_beat(CMD_READ, 8'h03, 8'h02, 1'b0, 1'b1);
    fill_ticks(FRAME_PHASES + 1, 0, 2);
    push_beat(CMD_INIT, 8'h04, 8'h03, 1'b0, 1'b0);
    fill_ticks(0, 0, 2);
    idle_tick();

    // hold off until every expected beat is back
    while (pending_q.size() != 0 || in_valid_i || exp_pins_q.size() != 0) @(negedge clk_i);

    // random frames with stray starts and idle ticks as noise
    rnd_target = beats_made + RANDOM_BEATS;
    while (beats_made < rnd_target) begin
      if ($urandom_range(99) < 15) begin
        idle_tick();
      end else begin
        pick = $urandom_range(99);
        if (pick < 35)
          push_beat(CMD_WRITE, 8'($urandom_range(255)), 8'($urandom_range(255)),
                    1'($urandom_range(1)), 1'($urandom_range(1)));
        else if (pick < 70)
          push_beat(CMD_READ, 8'($urandom_range(255)),
                    ($urandom_range(99) < 85) ? 8'($urandom_range(4, 1)) :
                                                8'($urandom_range(255)),
                    1'($urandom_range(1)), 1'($urandom_range(1)));
        else
          push_beat(CMD_INIT, 8'($urandom_range(255)), 8'($urandom_range(255)),
                    1'($urandom_range(1)), 1'($urandom_range(1)));
        fill_ticks(0, 3, 2);
      end
    end

    // drain and let the output register settle
    while (pending_q.size() != 0 || in_valid_i || exp_pins_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (exp_pins_q.size() != 0)
      note_mismatch($sformatf("%0d expected results never arrived", exp_pins_q.size()));

    if (err_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
